@@ rtl/core/fps_pkg.sv @@
package fps_pkg;

  // Node index width default.
  localparam int NODE_ID_WIDTH_DEF = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
  localparam logic [2:0] REG_FORWARD      = 3'd3;
  localparam logic [2:0] REG_OBJECT_SCALE = 3'd4;
  localparam logic [2:0] REG_FOVEATION    = 3'd5;

  // Register reset values.
  localparam logic [47:0] FORWARD_RESET = 48'h8000_0000_0000;
  localparam logic [31:0] SCALE_RESET   = 32'h0001_0000;
  localparam logic [63:0] FOV_RESET     = 64'h8000_8000_8000_8000;

  // Fixed point constants.
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [31:0] PIX_MAX = 32'hFFFF_FFFF;

  // Zone codes.
  localparam logic [2:0] ZONE_BEHIND = 3'd0;
  localparam logic [2:0] ZONE_INNER  = 3'd1;
  localparam logic [2:0] ZONE_BLEND  = 3'd2;
  localparam logic [2:0] ZONE_TAIL   = 3'd3;
  localparam logic [2:0] ZONE_ZERO   = 3'd4;

  // Pipeline step schedule.
  localparam int ST_DELTA  = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_SUM    = 2;
  localparam int ST_SQ0    = 3;
  localparam int SQ_STEPS  = 34;
  localparam int ST_DSET   = ST_SQ0 + SQ_STEPS;
  localparam int ST_DIV0   = ST_DSET + 1;
  localparam int D_STEPS   = 16;
  localparam int B_STEPS   = 47;
  localparam int ST_ZONE   = ST_DIV0 + D_STEPS;
  localparam int ST_RDIV0  = ST_ZONE + 1;
  localparam int R_STEPS   = 16;
  localparam int ST_FOV    = ST_RDIV0 + R_STEPS;
  localparam int ST_PP     = ST_DIV0 + B_STEPS;
  localparam int ST_FIN    = ST_PP + 1;
  localparam int NSTEP     = ST_FIN + 1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic [47:0]        fwd;
    logic [31:0]        scale;
    logic [15:0]        pen;
    logic [15:0]        fovp;
    logic [15:0]        inner;
    logic [15:0]        outer;
  } cfg_t;

endpackage

@@ rtl/core/fps_node_if.sv @@
interface fps_node_if #(
  parameter int ID_W = 24
);
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   node_id;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [31:0]       node_size;

  modport source (output valid, node_id, center_x, center_y, center_z, node_size,
                  input ready);
  modport sink (input valid, node_id, center_x, center_y, center_z, node_size,
                output ready);
endinterface

@@ rtl/core/fps_result_if.sv @@
interface fps_result_if #(
  parameter int ID_W = 24
);
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] result_id;
  logic [31:0]     fov_scale;
  logic [2:0]      zone;

  modport source (output valid, result_id, fov_scale, zone, input ready);
  modport sink (input valid, result_id, fov_scale, zone, output ready);
endinterface

@@ rtl/core/fps_cfg_if.sv @@
interface fps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/foveated_pixel_scale_core.sv @@
// Channel  | Dir | Payload
// node     | in  | node_id, center_x, center_y, center_z, node_size
// result   | out | result_id, fov_scale, zone
// cfg      | in  | index, data (register write, always ready)
//
// One node enters per cycle while the result side is not stalled.
// The longest path through the pipeline is the 34-step square root followed by the 47-step
// restoring division for the base scale, one bit per stage.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// A stalled result freezes every stage, so nothing is dropped or repeated.
module foveated_pixel_scale_core
  import fps_pkg::*;
#(
  parameter int NODE_ID_WIDTH = NODE_ID_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fps_node_if.sink     node,
  fps_result_if.source result,
  fps_cfg_if.sink      cfg
);

  typedef struct packed {
    logic [NODE_ID_WIDTH-1:0] id;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        size;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [65:0]        sq0;
    logic [65:0]        sq1;
    logic [65:0]        sq2;
    logic signed [48:0] fp0;
    logic signed [48:0] fp1;
    logic signed [48:0] fp2;
    logic [63:0]        nprod;
    logic [67:0]        rad;
    logic               zero;
    logic signed [50:0] fdot;
    logic [33:0]        root;
    logic [35:0]        srem;
    logic               big;
    logic [46:0]        bnum;
    logic [34:0]        brem;
    logic [46:0]        bq;
    logic               dneg;
    logic               dovf;
    logic [15:0]        dnum;
    logic [34:0]        drem;
    logic [15:0]        dq;
    logic [2:0]         zone;
    logic [15:0]        fovc;
    logic               rdiv;
    logic               rneg;
    logic [15:0]        rnum;
    logic [15:0]        rden;
    logic [15:0]        rrem;
    logic [15:0]        rq;
    logic [15:0]        fov;
    logic [39:0]        pp_lo;
    logic [38:0]        pp_hi;
    logic [31:0]        pix;
  } pipe_t;

  // One pipeline step; the step index selects which operations apply.
  function automatic pipe_t step(input int s, input pipe_t p, input cfg_t c);
    pipe_t              q;
    logic [32:0]        m0;
    logic [32:0]        m1;
    logic [32:0]        m2;
    logic [35:0]        sr;
    logic [35:0]        st;
    logic [34:0]        dr;
    logic [16:0]        rr;
    logic [15:0]        oe;
    logic signed [16:0] a17;
    logic signed [16:0] b17;
    logic signed [33:0] num;
    logic [33:0]        anum;
    logic [16:0]        fsum;
    logic [62:0]        prod;
    q = p;
    if (s == ST_DELTA) begin
      q.dx = 33'(p.cx) - 33'(c.ox);
      q.dy = 33'(p.cy) - 33'(c.oy);
      q.dz = 33'(p.cz) - 33'(c.oz);
    end
    if (s == ST_MUL) begin
      m0 = p.dx[32] ? 33'(-p.dx) : 33'(p.dx);
      m1 = p.dy[32] ? 33'(-p.dy) : 33'(p.dy);
      m2 = p.dz[32] ? 33'(-p.dz) : 33'(p.dz);
      q.sq0 = {33'b0, m0} * {33'b0, m0};
      q.sq1 = {33'b0, m1} * {33'b0, m1};
      q.sq2 = {33'b0, m2} * {33'b0, m2};
      q.fp0 = p.dx * $signed(c.fwd[15:0]);
      q.fp1 = p.dy * $signed(c.fwd[31:16]);
      q.fp2 = p.dz * $signed(c.fwd[47:32]);
      q.nprod = {32'b0, p.size} * {32'b0, c.scale};
    end
    if (s == ST_SUM) begin
      q.rad  = 68'(p.sq0) + 68'(p.sq1) + 68'(p.sq2);
      q.zero = (p.dx == '0) && (p.dy == '0) && (p.dz == '0);
      q.fdot = 51'(p.fp0) + 51'(p.fp1) + 51'(p.fp2);
      q.root = '0;
      q.srem = '0;
    end
    // Digit-by-digit square root, one result bit per step.
    if (s >= ST_SQ0 && s < ST_SQ0 + SQ_STEPS) begin
      sr = {p.srem[33:0], p.rad[67:66]};
      st = {p.root, 2'b01};
      if (sr >= st) begin
        q.srem = sr - st;
        q.root = {p.root[32:0], 1'b1};
      end else begin
        q.srem = sr;
        q.root = {p.root[32:0], 1'b0};
      end
      q.rad = {p.rad[65:0], 2'b00};
    end
    // Division setup: the quotients are bounded, so overflow is a compare.
    if (s == ST_DSET) begin
      q.big  = {17'b0, p.nprod[63:47]} >= p.root;
      q.brem = {18'b0, p.nprod[63:47]};
      q.bnum = p.nprod[46:0];
      q.bq   = '0;
      q.dneg = (p.fdot <= 51'sd0);
      q.dovf = p.fdot[49:16] >= p.root;
      q.drem = {1'b0, p.fdot[49:16]};
      q.dnum = p.fdot[15:0];
      q.dq   = '0;
    end
    // Normalized dot, one quotient bit per step.
    if (s >= ST_DIV0 && s < ST_DIV0 + D_STEPS) begin
      dr = {p.drem[33:0], p.dnum[15]};
      if (dr >= {1'b0, p.root}) begin
        q.drem = dr - {1'b0, p.root};
        q.dq   = {p.dq[14:0], 1'b1};
      end else begin
        q.drem = dr;
        q.dq   = {p.dq[14:0], 1'b0};
      end
      q.dnum = {p.dnum[14:0], 1'b0};
    end
    // Base scale, one quotient bit per step.
    if (s >= ST_DIV0 && s < ST_DIV0 + B_STEPS) begin
      dr = {p.brem[33:0], p.bnum[46]};
      if (dr >= {1'b0, p.root}) begin
        q.brem = dr - {1'b0, p.root};
        q.bq   = {p.bq[45:0], 1'b1};
      end else begin
        q.brem = dr;
        q.bq   = {p.bq[45:0], 1'b0};
      end
      q.bnum = {p.bnum[45:0], 1'b0};
    end
    // Zone choice and ramp numerator.
    if (s == ST_ZONE) begin
      oe     = (c.outer > c.inner) ? c.inner : c.outer;
      q.rdiv = 1'b0;
      q.rden = c.inner - oe;
      a17    = '0;
      b17    = '0;
      if (p.zero) begin
        q.zone = ZONE_ZERO;
        q.fovc = ONE_Q15;
      end else if (p.dneg) begin
        q.zone = ZONE_BEHIND;
        q.fovc = c.pen;
      end else if (p.dovf || p.dq >= c.inner) begin
        q.zone = ZONE_INNER;
        q.fovc = ONE_Q15;
      end else if (p.dq >= oe) begin
        q.zone = ZONE_BLEND;
        if (q.rden == '0) begin
          q.fovc = ONE_Q15;
        end else begin
          q.fovc = c.fovp;
          q.rdiv = 1'b1;
          a17 = $signed({1'b0, ONE_Q15}) - $signed({1'b0, c.fovp});
          b17 = $signed({1'b0, p.dq}) - $signed({1'b0, oe});
        end
      end else begin
        q.zone = ZONE_TAIL;
        q.fovc = c.pen;
        q.rden = oe;
        if (oe != '0) begin
          q.rdiv = 1'b1;
          a17 = $signed({1'b0, c.fovp}) - $signed({1'b0, c.pen});
          b17 = $signed({1'b0, p.dq});
        end
      end
      num    = a17 * b17;
      q.rneg = num[33];
      anum   = num[33] ? 34'(-num) : 34'(num);
      q.rrem = anum[31:16];
      q.rnum = anum[15:0];
      q.rq   = '0;
    end
    // Ramp quotient, truncated toward zero.
    if (s >= ST_RDIV0 && s < ST_RDIV0 + R_STEPS) begin
      rr = {p.rrem, p.rnum[15]};
      if (rr >= {1'b0, p.rden}) begin
        q.rrem = 16'(rr - {1'b0, p.rden});
        q.rq   = {p.rq[14:0], 1'b1};
      end else begin
        q.rrem = rr[15:0];
        q.rq   = {p.rq[14:0], 1'b0};
      end
      q.rnum = {p.rnum[14:0], 1'b0};
    end
    if (s == ST_FOV) begin
      if (!p.rdiv) begin
        fsum = {1'b0, p.fovc};
      end else if (p.rneg) begin
        fsum = {1'b0, p.fovc} - {1'b0, p.rq};
      end else begin
        fsum = {1'b0, p.fovc} + {1'b0, p.rq};
      end
      q.fov = fsum[15:0];
    end
    // Final scale product in two halves.
    if (s == ST_PP) begin
      q.pp_lo = {16'b0, p.bq[23:0]} * {24'b0, p.fov};
      q.pp_hi = {16'b0, p.bq[46:24]} * {23'b0, p.fov};
    end
    if (s == ST_FIN) begin
      prod = 63'(p.pp_lo) + {p.pp_hi[38:0], 24'b0};
      if (p.zero) begin
        q.pix = PIX_MAX;
      end else if (p.fov == '0) begin
        q.pix = '0;
      end else if (p.big || prod[62:47] != '0) begin
        q.pix = PIX_MAX;
      end else begin
        q.pix = prod[46:15];
      end
    end
    return q;
  endfunction

  // Configuration registers.
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [47:0]        forward_vector;
  logic [31:0]        obj_scale;
  logic [63:0]        foveation_params;
  cfg_t               cfg_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x         <= '0;
      origin_y         <= '0;
      origin_z         <= '0;
      forward_vector   <= FORWARD_RESET;
      obj_scale        <= SCALE_RESET;
      foveation_params <= FOV_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ORIGIN_X:     origin_x         <= cfg.data[31:0];
        REG_ORIGIN_Y:     origin_y         <= cfg.data[31:0];
        REG_ORIGIN_Z:     origin_z         <= cfg.data[31:0];
        REG_FORWARD:      forward_vector   <= cfg.data[47:0];
        REG_OBJECT_SCALE: obj_scale        <= cfg.data[31:0];
        REG_FOVEATION:    foveation_params <= cfg.data;
        default: ;
      endcase
    end
  end

  // A zero object scale acts as 1.0.
  always_comb begin
    cfg_c.ox    = origin_x;
    cfg_c.oy    = origin_y;
    cfg_c.oz    = origin_z;
    cfg_c.fwd   = forward_vector;
    cfg_c.scale = (obj_scale == '0) ? SCALE_RESET : obj_scale;
    cfg_c.pen   = foveation_params[15:0];
    cfg_c.fovp  = foveation_params[31:16];
    cfg_c.inner = foveation_params[47:32];
    cfg_c.outer = foveation_params[63:48];
  end

  // Pipeline registers and their valid bits; one enable moves them all.
  pipe_t        pipe [NSTEP+1];
  pipe_t        pipe_next [NSTEP+1];
  logic [NSTEP:0] vld;
  logic         en;

  assign en         = !vld[NSTEP] || result.ready;
  assign node.ready = en;

  always_comb begin
    pipe_next[0]      = pipe[0];
    pipe_next[0].id   = node.node_id;
    pipe_next[0].cx   = node.center_x;
    pipe_next[0].cy   = node.center_y;
    pipe_next[0].cz   = node.center_z;
    pipe_next[0].size = node.node_size;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_comb begin
      pipe_next[k+1] = step(k, pipe[k], cfg_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTEP-1:0], node.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NSTEP; k++) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign result.valid     = vld[NSTEP];
  assign result.result_id = pipe[NSTEP].id;
  assign result.fov_scale = pipe[NSTEP].pix;
  assign result.zone      = pipe[NSTEP].zone;

  // A zero-distance node always leaves as the saturated zone-four item.
  a_zero_zone : assert property (@(posedge clk) disable iff (rst)
    (vld[NSTEP] && pipe[NSTEP].zero) |-> (result.zone == ZONE_ZERO &&
      result.fov_scale == PIX_MAX))
    else $error("zero distance item left with wrong zone or scale");

  // The input side only stalls when a finished item is waiting.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !node.ready |-> (vld[NSTEP] && !result.ready))
    else $error("input stalled without a waiting item");

  // A frozen pipeline keeps its occupancy.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // The ramp never pushes an inner-cone item below full weight.
  a_inner : assert property (@(posedge clk) disable iff (rst)
    (vld[NSTEP] && pipe[NSTEP].zone == ZONE_INNER) |-> pipe[NSTEP].fov == ONE_Q15)
    else $error("inner cone item without unit factor");

endmodule

@@ sim/tb_foveated_pixel_scale_core.sv @@
module tb_foveated_pixel_scale_core
  import fps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W = 24;
  localparam int LATENCY = 88;
  localparam int N_RANDOM = 1120;

  typedef struct {
    logic [ID_W-1:0] node_id;
    logic [31:0]     cx;
    logic [31:0]     cy;
    logic [31:0]     cz;
    logic [31:0]     size;
  } node_item_t;

  typedef struct {
    logic [ID_W-1:0] result_id;
    logic [31:0]     fov_scale;
    logic [2:0]      zone;
  } scale_item_t;

  // One directed node, with an optional typed-in answer.
  typedef struct {
    node_item_t  n;
    bit          known;
    logic [31:0] pix;
    logic [2:0]  zone;
  } directed_row_t;

  logic clk;
  logic rst;

  fps_node_if #(.ID_W(ID_W)) node_ch ();
  fps_result_if #(.ID_W(ID_W)) result_ch ();
  fps_cfg_if cfg_ch ();

  foveated_pixel_scale_core #(.NODE_ID_WIDTH(ID_W)) DUT (
    .clk(clk),
    .rst(rst),
    .node(node_ch.sink),
    .result(result_ch.source),
    .cfg(cfg_ch.sink)
  );

  // Local copy of the camera and foveation registers.
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [47:0]        fwd_vec;
  logic [31:0]        obj_scale;
  logic [63:0]        fov_params;

  scale_item_t expected_scales[$];
  int          mismatch_count;
  bit          stim_done;

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Computes the foveated scale of one node under the current registers.
  function automatic scale_item_t predict_scale(input node_item_t n);
    scale_item_t r;
    logic signed [33:0]  dx, dy, dz;
    logic [67:0]         sumsq;
    logic [67:0]         trial;
    logic [33:0]         root_dist;
    logic [33:0]         cand;
    logic [63:0]         scl;
    logic [63:0]         base;
    logic signed [63:0]  fdot;
    logic [63:0]         d;
    logic [15:0]         pen, fovp, inner, outer;
    logic signed [63:0]  num;
    logic [31:0]         den;
    logic [31:0]         fov;
    logic [127:0]        prod;
    logic [127:0]        shifted;
    r.result_id = n.node_id;
    dx = $signed(n.cx) - cam_x;
    dy = $signed(n.cy) - cam_y;
    dz = $signed(n.cz) - cam_z;
    sumsq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    if (sumsq == 0) begin
      r.fov_scale = PIX_MAX;
      r.zone = ZONE_ZERO;
      return r;
    end
    root_dist = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root_dist | (34'd1 << b);
      trial = 68'(cand) * 68'(cand);
      if (trial <= sumsq) root_dist = cand;
    end
    scl = (obj_scale == 0) ? 64'd65536 : 64'(obj_scale);
    base = (64'(n.size) * scl) / 64'(root_dist);
    pen = fov_params[15:0];
    fovp = fov_params[31:16];
    inner = fov_params[47:32];
    outer = fov_params[63:48];
    if (outer > inner) outer = inner;
    fdot = 64'(dx) * 64'($signed(fwd_vec[15:0]))
         + 64'(dy) * 64'($signed(fwd_vec[31:16]))
         + 64'(dz) * 64'($signed(fwd_vec[47:32]));
    if (fdot <= 0) begin
      r.zone = ZONE_BEHIND;
      fov = 32'(pen);
    end else begin
      d = 64'(fdot) / 64'(root_dist);
      if (d >= 64'(inner)) begin
        r.zone = ZONE_INNER;
        fov = 32'(ONE_Q15);
      end else if (d >= 64'(outer)) begin
        r.zone = ZONE_BLEND;
        den = 32'(inner) - 32'(outer);
        if (den == 0) begin
          fov = 32'(ONE_Q15);
        end else begin
          num = (64'sd32768 - $signed({48'd0, fovp})) * $signed(d - 64'(outer));
          fov = 32'($signed({48'd0, fovp}) + num / $signed({32'd0, den}));
        end
      end else begin
        r.zone = ZONE_TAIL;
        if (outer == 0) begin
          fov = 32'(pen);
        end else begin
          num = ($signed({48'd0, fovp}) - $signed({48'd0, pen})) * $signed(d);
          fov = 32'($signed({48'd0, pen}) + num / $signed({48'd0, outer}));
        end
      end
    end
    prod = 128'(base) * 128'(fov);
    shifted = prod >> 15;
    r.fov_scale = (shifted > 128'(PIX_MAX)) ? PIX_MAX : shifted[31:0];
    return r;
  endfunction

  // Result receiver with its own stall pattern, checking in order.
  initial begin
    int stall_phase;
    scale_item_t want;
    result_ch.ready = 1'b0;
    stall_phase = 0;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready && !rst) begin
        if (expected_scales.size() == 0) begin
          report_mismatch("unexpected result id", 64'(result_ch.result_id), 64'd0);
        end else begin
          want = expected_scales.pop_front();
          if (result_ch.result_id !== want.result_id)
            report_mismatch("result_id", 64'(result_ch.result_id), 64'(want.result_id));
          if (result_ch.fov_scale !== want.fov_scale)
            report_mismatch("fov_scale", 64'(result_ch.fov_scale),
                            64'(want.fov_scale));
          if (result_ch.zone !== want.zone)
            report_mismatch("zone", 64'(result_ch.zone), 64'(want.zone));
        end
      end
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) result_ch.ready <= 1'b1;
      else if (stall_phase < 300) result_ch.ready <= ($urandom_range(0, 3) != 0);
      else result_ch.ready <= ($urandom_range(0, 1) != 0);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X:     cam_x = value[31:0];
      REG_ORIGIN_Y:     cam_y = value[31:0];
      REG_ORIGIN_Z:     cam_z = value[31:0];
      REG_FORWARD:      fwd_vec = value[47:0];
      REG_OBJECT_SCALE: obj_scale = value[31:0];
      REG_FOVEATION:    fov_params = value;
      default: ;
    endcase
  endtask

  // Waits for the pipeline to drain before reconfiguring.
  task automatic wait_idle();
    while (expected_scales.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Sends one node; the burst gap is taken before it.
  task automatic send_node(input node_item_t n, input bit known,
                           input logic [31:0] pix, input logic [2:0] zone,
                           inout int burst_left);
    scale_item_t e;
    if (burst_left == 0) begin
      node_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    node_ch.valid     <= 1'b1;
    node_ch.node_id   <= n.node_id;
    node_ch.center_x  <= n.cx;
    node_ch.center_y  <= n.cy;
    node_ch.center_z  <= n.cz;
    node_ch.node_size <= n.size;
    e = predict_scale(n);
    if (known) begin
      e.fov_scale = pix;
      e.zone = zone;
    end
    expected_scales.insert(expected_scales.size(), e);
    do @(posedge clk); while (!node_ch.ready);
  endtask

  task automatic end_phase(inout int burst_left);
    node_ch.valid <= 1'b0;
    burst_left = 0;
    wait_idle();
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [47:0] rand_forward();
    case ($urandom_range(0, 3))
      0: return {16'h8000, 16'h0000, 16'h0000};
      1: return {16'h0000, 16'h0000, 16'h7FFF};
      2: return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
      default: return {16'h5A82, 16'h0000, 16'h5A82};
    endcase
  endfunction

  // Stimulus: directed table, then random phases with varied registers.
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    node_item_t n;
    int burst_left;
    int mode;
    logic [15:0] p16, f16, i16, o16;
    rst = 1'b1;
    stim_done = 1'b0;
    node_ch.valid = 1'b0;
    node_ch.node_id = '0;
    node_ch.center_x = '0;
    node_ch.center_y = '0;
    node_ch.center_z = '0;
    node_ch.node_size = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORIGIN_X;
    cfg_ch.data = '0;
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    fwd_vec = FORWARD_RESET;
    obj_scale = SCALE_RESET;
    fov_params = FOV_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Under reset registers: zero distance, behind, inner cone, extremes.
    rows.insert(rows.size(), '{'{24'h000000, 32'd0, 32'd0, 32'd0, 32'd5},
                               1'b1, PIX_MAX, ZONE_ZERO});
    rows.insert(rows.size(), '{'{24'hFFFFFF, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000},
                               1'b1, 32'h0001_0000, ZONE_BEHIND});
    rows.insert(rows.size(), '{'{24'h123456, 32'd0, 32'd0, 32'hFFFF_0000, 32'h0002_0000},
                               1'b1, 32'h0002_0000, ZONE_INNER});
    rows.insert(rows.size(), '{'{24'h00000F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'hFFFF_FFFF}, 1'b0, '0, '0});
    rows.insert(rows.size(), '{'{24'hABCDEF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'hFFFF_FFFF}, 1'b0, '0, '0});
    rows.insert(rows.size(), '{'{24'h555555, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                               1'b1, PIX_MAX, ZONE_INNER});
    rows.insert(rows.size(), '{'{24'hAAAAAA, 32'd1, 32'd0, 32'd0, 32'd0},
                               1'b1, 32'd0, ZONE_BEHIND});
    burst_left = 0;
    foreach (rows[i]) begin
      row = rows[i];
      send_node(row.n, row.known, row.pix, row.zone, burst_left);
    end
    end_phase(burst_left);

    // Blend band, tail and outer-above-inner, with zero scale acting as one.
    write_reg(REG_OBJECT_SCALE, 64'd0);
    write_reg(REG_FORWARD, {16'h8000, 16'h0000, 16'h0000});
    write_reg(REG_FOVEATION, {16'h6000, 16'h7000, 16'h4000, 16'h1000});
    for (int k = 0; k < 16; k++) begin
      n.node_id = 24'(k);
      n.cx = 32'h0001_0000;
      n.cy = 32'(k * 32'h0000_2000);
      n.cz = 32'hFFFF_0000 + 32'(k * 32'h0000_1000);
      n.size = 32'h0004_0000;
      send_node(n, 1'b0, '0, '0, burst_left);
    end
    end_phase(burst_left);
    write_reg(REG_FOVEATION, {16'h7000, 16'h4000, 16'h5000, 16'h0000});
    for (int k = 0; k < 4; k++) begin
      n.node_id = 24'(k);
      n.cx = 32'h0001_0000;
      n.cy = 32'd0;
      n.cz = 32'hFFFF_8000 - 32'(k * 32'h0000_8000);
      n.size = 32'h0001_0000;
      send_node(n, 1'b0, '0, '0, burst_left);
    end
    end_phase(burst_left);

    // Random phases, each with new register settings.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_ORIGIN_X, (ph == 1) ? 64'h8000_0000 : (ph == 2) ? 64'h7FFF_FFFF
                              : 64'(rand_coord(1 + ph % 2)));
      write_reg(REG_ORIGIN_Y, (ph == 1) ? 64'h7FFF_FFFF : 64'(rand_coord(1 + ph % 2)));
      write_reg(REG_ORIGIN_Z, (ph == 2) ? 64'h8000_0000 : 64'(rand_coord(1 + ph % 2)));
      write_reg(REG_FORWARD, (ph == 3) ? 64'hFFFF_FFFF_FFFF : (ph == 4) ? 64'd0
                             : 64'(rand_forward()));
      write_reg(REG_OBJECT_SCALE, (ph == 5) ? 64'hFFFF_FFFF : (ph == 6) ? 64'd1
                                  : (ph == 7) ? 64'd0
                                  : 64'($urandom_range(32'h0000_4000, 32'h0008_0000)));
      p16 = 16'($urandom_range(0, 16'h8000));
      f16 = 16'($urandom_range(0, 16'h8000));
      i16 = 16'($urandom_range(0, 16'h8000));
      o16 = 16'($urandom_range(0, 16'h8000));
      if (ph == 8) {p16, f16, i16, o16} = '1;
      if (ph == 9) {p16, f16, i16, o16} = '0;
      if (ph == 10) o16 = i16;
      write_reg(REG_FOVEATION, {o16, i16, f16, p16});
      for (int k = 0; k < N_RANDOM / 14; k++) begin
        mode = $urandom_range(0, 9);
        n.node_id = 24'($urandom());
        n.cx = (mode == 0) ? 32'($urandom()) : cam_x + rand_coord(1 + k % 2);
        n.cy = (mode == 0) ? 32'($urandom()) : cam_y + rand_coord(1 + k % 2);
        n.cz = (mode == 0) ? 32'($urandom()) : cam_z + rand_coord(1 + k % 2);
        if (mode == 1) begin
          n.cx = cam_x;
          n.cy = cam_y;
          n.cz = cam_z;
        end
        n.size = (mode < 3) ? 32'($urandom()) : 32'($urandom_range(0, 32'h0010_0000));
        send_node(n, 1'b0, '0, '0, burst_left);
      end
      end_phase(burst_left);
    end
    stim_done = 1'b1;
  end

  // Final verdict once all stimulus has drained.
  initial begin
    wait (stim_done);
    while (expected_scales.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_scales.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
